[sv/msec_pkg.sv]
// Shared types and constants for the MIPS subset execute core.
package msec_pkg;

  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned REG_AW   = 5;
  localparam int unsigned XLEN     = 32;
  localparam int unsigned LEN_W    = 11;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_MUL     = 6'd28;

  localparam logic [10:0] FN_SYSCALL = 11'd12;
  localparam logic [10:0] FN_ADD     = 11'd32;
  localparam logic [10:0] FN_SUB     = 11'd34;
  localparam logic [10:0] FN_SLT     = 11'd42;

  localparam logic [XLEN-1:0] SYS_PRINT_INT  = 32'd1;
  localparam logic [XLEN-1:0] SYS_EXIT       = 32'd10;
  localparam logic [XLEN-1:0] SYS_PRINT_CHAR = 32'd11;

  localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_AW-1:0] REG_V0   = 5'd2;
  localparam logic [REG_AW-1:0] REG_A0   = 5'd4;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EXIT        = 3'd1,
    ST_BAD_SYSCALL = 3'd2,
    ST_INVALID     = 3'd3,
    ST_BR_BEFORE   = 3'd4,
    ST_BR_AFTER    = 3'd5,
    ST_END         = 3'd6,
    ST_HALTED      = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_INT  = 2'd1,
    PK_CHAR = 2'd2
  } pkind_t;

  // Outcome of one executed instruction, except the next pc whose width
  // follows the program depth.
  typedef struct packed {
    logic              wr_en;
    logic [REG_AW-1:0] wr_addr;
    logic [XLEN-1:0]   wr_data;
    logic              halt;
    logic              pc_load;
    status_t           status;
    pkind_t            kind;
    logic [XLEN-1:0]   print_value;
  } exec_res_t;

endpackage

[sv/mips_subset_execute_core.sv]
// Top level of the MIPS subset execute core: channels, state and pipeline registers.
//
// Usage: the environment fetches the instruction word at the program counter
// last reported (out_next_pc of the previous result, 0 after reset) and sends it
// as one transaction on the in_ channel. The block executes add, sub, slt, mul,
// beq, bne, addi, ori, lui and syscall, and returns exactly one result
// transaction per instruction on the out_ channel: exec_pc, next_pc, status and
// any syscall print (kind and value of register 4).
// Write program_length on the cfg_ channel while the block is idle; lengths
// above PROG_DEPTH are clipped to PROG_DEPTH. cfg_ready is always high.
// Pipeline: execute register, then output register for the result.
// Throughput: one instruction per cycle while out_ready is high; the register file
// is read at the accepting edge and a write from the instruction ahead is bypassed.
// Stall: while out_ready is low the result holds in the output register, one
// more instruction may sit in the execute register, then in_ready drops.
// Reset (synchronous, rst_n low): registers read zero, pc is 0, the block is
// not halted, program_length is 0 and both pipeline stages are empty.
// After a halting status every further instruction returns status halted.
module mips_subset_execute_core #(
  parameter int unsigned PROG_DEPTH = 1024,
  parameter int unsigned PC_W       = $clog2(PROG_DEPTH),
  parameter int unsigned NPC_W      = ((PC_W > 15) ? PC_W : 15) + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [msec_pkg::LEN_W-1:0]  cfg_program_length,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [31:0]                 in_instr_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [PC_W-1:0]             out_exec_pc,
  output logic signed [NPC_W-1:0]     out_next_pc,
  output logic [2:0]                  out_status,
  output logic [1:0]                  out_print_kind,
  output logic signed [31:0]          out_print_value
);
  import msec_pkg::*;

  // Configuration
  logic [LEN_W-1:0] prog_len_r;

  // Architectural state
  logic [PC_W-1:0] pc_r;
  logic            halted_r;

  // Execute stage
  logic        ex_valid_r;
  logic [31:0] instr_r;

  // Output stage
  logic             out_valid_r;
  logic [PC_W-1:0]  out_exec_pc_r;
  logic [NPC_W-1:0] out_next_pc_r;
  logic [2:0]       out_status_r;
  logic [1:0]       out_print_kind_r;
  logic [31:0]      out_print_value_r;

  logic              in_accept;
  logic              ex_advance;
  logic              is_syscall;
  logic [REG_AW-1:0] rd_addr_a, rd_addr_b;
  logic [XLEN-1:0]   rs_val, rt_val;
  exec_res_t         res;
  logic [NPC_W-1:0]  next_pc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      prog_len_r <= cfg_program_length;
    end
  end

  // Advance the execute stage when the output register is free or draining.
  assign ex_advance = ex_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !ex_valid_r || ex_advance;
  assign in_accept  = in_valid && in_ready;

  // A syscall reads register 2 (call number) and register 4 (argument).
  assign is_syscall = (in_instr_word[31:26] == OP_SPECIAL) &&
                      (in_instr_word[10:0] == FN_SYSCALL);
  assign rd_addr_a  = is_syscall ? REG_V0 : in_instr_word[25:21];
  assign rd_addr_b  = is_syscall ? REG_A0 : in_instr_word[20:16];

  msec_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_en     (ex_advance && res.wr_en),
    .wr_addr   (res.wr_addr),
    .wr_data   (res.wr_data),
    .rd_data_a (rs_val),
    .rd_data_b (rt_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else if (in_accept) begin
      ex_valid_r <= 1'b1;
    end else if (ex_advance) begin
      ex_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      instr_r <= in_instr_word;
    end
  end

  msec_alu #(
    .PROG_DEPTH (PROG_DEPTH),
    .PC_W       (PC_W),
    .NPC_W      (NPC_W)
  ) u_alu (
    .instr    (instr_r),
    .rs       (rs_val),
    .rt       (rt_val),
    .pc       (pc_r),
    .halted   (halted_r),
    .prog_len (prog_len_r),
    .res      (res),
    .next_pc  (next_pc)
  );

  // Commit pc and halt as the instruction leaves the execute stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      halted_r <= 1'b0;
    end else if (ex_advance) begin
      if (res.pc_load) begin
        pc_r <= next_pc[PC_W-1:0];
      end
      if (res.halt) begin
        halted_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ex_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_advance) begin
      out_exec_pc_r     <= pc_r;
      out_next_pc_r     <= next_pc;
      out_status_r      <= res.status;
      out_print_kind_r  <= res.kind;
      out_print_value_r <= res.print_value;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_exec_pc     = out_exec_pc_r;
  assign out_next_pc     = out_next_pc_r;
  assign out_status      = out_status_r;
  assign out_print_kind  = out_print_kind_r;
  assign out_print_value = out_print_value_r;

endmodule

[sv/msec_regfile.sv]
// Register file: 32 x 32 memory with registered reads, reset valid bits and write bypass.
module msec_regfile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [msec_pkg::REG_AW-1:0] rd_addr_a,
  input  logic [msec_pkg::REG_AW-1:0] rd_addr_b,
  input  logic                        wr_en,
  input  logic [msec_pkg::REG_AW-1:0] wr_addr,
  input  logic [msec_pkg::XLEN-1:0]   wr_data,
  output logic [msec_pkg::XLEN-1:0]   rd_data_a,
  output logic [msec_pkg::XLEN-1:0]   rd_data_b
);
  import msec_pkg::*;

  logic [XLEN-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;

  logic [XLEN-1:0] rd_q_a_r, rd_q_b_r;
  logic            vld_a_r, vld_b_r;
  logic            byp_a_r, byp_b_r;
  logic [XLEN-1:0] byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_a_r <= mem[rd_addr_a];
      rd_q_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Capture valid and same-edge write bypass alongside the read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_a_r    <= vld_r[rd_addr_a];
      vld_b_r    <= vld_r[rd_addr_b];
      byp_a_r    <= wr_en && (wr_addr == rd_addr_a);
      byp_b_r    <= wr_en && (wr_addr == rd_addr_b);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data_a = byp_a_r ? byp_data_r : (vld_a_r ? rd_q_a_r : '0);
  assign rd_data_b = byp_b_r ? byp_data_r : (vld_b_r ? rd_q_b_r : '0);

endmodule

[sv/msec_alu.sv]
// Decode and execute logic: ALU, multiplier, branch target and status checks.
module msec_alu #(
  parameter int unsigned PROG_DEPTH = 1024,
  parameter int unsigned PC_W       = 10,
  parameter int unsigned NPC_W      = 17
) (
  input  logic [31:0]                instr,
  input  logic [msec_pkg::XLEN-1:0]  rs,
  input  logic [msec_pkg::XLEN-1:0]  rt,
  input  logic [PC_W-1:0]            pc,
  input  logic                       halted,
  input  logic [msec_pkg::LEN_W-1:0] prog_len,
  output msec_pkg::exec_res_t        res,
  output logic [NPC_W-1:0]           next_pc
);
  import msec_pkg::*;

  localparam logic [NPC_W-1:0] DEPTH_EXT = NPC_W'(PROG_DEPTH);

  logic [5:0]        op;
  logic [10:0]       fn;
  logic [REG_AW-1:0] t_addr, d_addr;
  logic [15:0]       imm;
  logic [NPC_W-1:0]  pc_ext, len_raw, eff_len, target, br_off;
  logic [XLEN-1:0]   prod;

  assign op      = instr[31:26];
  assign fn      = instr[10:0];
  assign t_addr  = instr[20:16];
  assign d_addr  = instr[15:11];
  assign imm     = instr[15:0];
  assign pc_ext  = {{(NPC_W-PC_W){1'b0}}, pc};
  assign len_raw = {{(NPC_W-LEN_W){1'b0}}, prog_len};
  assign eff_len = (len_raw > DEPTH_EXT) ? DEPTH_EXT : len_raw;
  assign br_off  = {{(NPC_W-16){imm[15]}}, imm};
  assign prod    = rs * rt;

  always_comb begin
    logic stop;
    logic taken;
    stop        = 1'b0;
    taken       = 1'b0;
    res.wr_en   = 1'b0;
    res.wr_addr = d_addr;
    res.wr_data = '0;
    res.halt    = 1'b0;
    res.pc_load = 1'b0;
    res.status  = ST_OK;
    res.kind    = PK_NONE;
    res.print_value = '0;
    target      = pc_ext + NPC_W'(1);
    next_pc     = pc_ext;

    if (halted) begin
      res.status = ST_HALTED;
    end else if (pc_ext >= eff_len) begin
      res.status = ST_END;
      res.halt   = 1'b1;
    end else begin
      case (op)
        OP_SPECIAL: begin
          case (fn)
            FN_ADD: begin
              res.wr_en   = 1'b1;
              res.wr_data = rs + rt;
            end
            FN_SUB: begin
              res.wr_en   = 1'b1;
              res.wr_data = rs - rt;
            end
            FN_SLT: begin
              res.wr_en   = 1'b1;
              res.wr_data = ($signed(rs) < $signed(rt)) ? 32'd1 : 32'd0;
            end
            FN_SYSCALL: begin
              // rs carries register 2, rt register 4 for a syscall
              if (rs == SYS_PRINT_INT) begin
                res.kind        = PK_INT;
                res.print_value = rt;
              end else if (rs == SYS_PRINT_CHAR) begin
                res.kind        = PK_CHAR;
                res.print_value = rt;
              end else if (rs == SYS_EXIT) begin
                stop       = 1'b1;
                res.status = ST_EXIT;
              end else begin
                stop       = 1'b1;
                res.status = ST_BAD_SYSCALL;
              end
            end
            default: begin
              stop       = 1'b1;
              res.status = ST_INVALID;
            end
          endcase
        end
        OP_MUL: begin
          res.wr_en   = 1'b1;
          res.wr_data = prod;
        end
        OP_BEQ: taken = (rs == rt);
        OP_BNE: taken = (rs != rt);
        OP_ADDI: begin
          res.wr_en   = 1'b1;
          res.wr_addr = t_addr;
          res.wr_data = rs + {{16{imm[15]}}, imm};
        end
        OP_ORI: begin
          res.wr_en   = 1'b1;
          res.wr_addr = t_addr;
          res.wr_data = rs | {16'd0, imm};
        end
        OP_LUI: begin
          res.wr_en   = 1'b1;
          res.wr_addr = t_addr;
          res.wr_data = {imm, 16'd0};
        end
        default: begin
          stop       = 1'b1;
          res.status = ST_INVALID;
        end
      endcase

      if (stop) begin
        res.halt = 1'b1;
      end else begin
        if (taken) begin
          target = pc_ext + br_off;
        end
        next_pc = target;
        if (target[NPC_W-1]) begin
          res.status = ST_BR_BEFORE;
          res.halt   = 1'b1;
        end else if (target > eff_len) begin
          res.status = ST_BR_AFTER;
          res.halt   = 1'b1;
        end else if (target == eff_len) begin
          res.status = ST_END;
          res.halt   = 1'b1;
        end else begin
          res.pc_load = 1'b1;
        end
      end
      // register 0 stays zero
      if (res.wr_addr == REG_ZERO) begin
        res.wr_en = 1'b0;
      end
    end
  end

endmodule
